// File: rtl/walk_first_passage_recorder_defines.svh
// Assertion macros for the walk first-passage recorder.
// Included by files that carry concurrent checks; depends on clk and rst_n in scope.
`ifndef WALK_FIRST_PASSAGE_RECORDER_DEFINES_SVH
`define WALK_FIRST_PASSAGE_RECORDER_DEFINES_SVH

`ifndef SYNTHESIS
`define WFPR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("walk recorder assertion failed");
`define WFPR_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("walk recorder forbidden condition seen");
`else
`define WFPR_ASSERT(lbl, prop)
`define WFPR_NEVER(lbl, cond)
`endif

`endif

// File: rtl/wfpr_pkg.sv
// Shared constants, types and helpers for the walk first-passage recorder.
// No dependencies; used by every module of the block.
package wfpr_pkg;

    localparam int unsigned NUM_LEVELS    = 15;
    localparam int unsigned MAX_DIMS      = 4;
    localparam int unsigned STEP_DIMS     = 4;
    localparam int unsigned QUEUE_DEPTH   = 4;
    localparam int unsigned BASE_LEVEL    = 8;
    localparam int unsigned COORD_W       = 32;
    localparam int unsigned COUNT_W       = 32;
    localparam int unsigned LIMIT_W       = 31;
    localparam int unsigned DIMS_W        = 3;
    localparam int unsigned LEVEL_IDX_W   = 4;
    localparam int unsigned CFG_ADDR_W    = 1;

    localparam logic [LIMIT_W-1:0] REGION_LIMIT_RESET = 31'd131072;
    localparam logic [DIMS_W-1:0]  DIMS_USED_RESET    = 3'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_REGION_LIMIT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DIMS_USED    = 1'd1;

    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_STEP    = 1'b1;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Distance of level k: BASE_LEVEL * 2^k.
    function automatic logic [COORD_W-1:0] level_threshold(input int unsigned k);
        logic [COORD_W-1:0] thr;
        thr = COORD_W'(BASE_LEVEL) << k;
        return thr;
    endfunction

endpackage

// File: rtl/wfpr_front.sv
// Front part: accepts step and restart transfers, updates the position and
// classifies each step into a burst of level records. Depends on wfpr_pkg.
module wfpr_front #(
    parameter int unsigned NUM_LEVELS = wfpr_pkg::NUM_LEVELS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_cmd,
    input  logic [wfpr_pkg::COORD_W-1:0]        in_step [wfpr_pkg::STEP_DIMS],
    input  logic [wfpr_pkg::LIMIT_W-1:0]        region_limit,
    input  logic [wfpr_pkg::DIMS_W-1:0]         dims_used,
    input  wfpr_pkg::q_status_t                 q_status,
    output logic                                push,
    output logic [NUM_LEVELS-1:0]               push_mask,
    output logic [wfpr_pkg::COUNT_W-1:0]        push_count,
    output logic                                push_end
);

    localparam int unsigned CW = wfpr_pkg::COORD_W;
    localparam int unsigned ND = wfpr_pkg::STEP_DIMS;
    localparam int unsigned DimLimit =
        (wfpr_pkg::MAX_DIMS < wfpr_pkg::STEP_DIMS) ? wfpr_pkg::MAX_DIMS : wfpr_pkg::STEP_DIMS;

    // Stage 1: position and per-dimension magnitude.
    logic [CW-1:0]          pos_reg   [ND];
    logic [CW-1:0]          pos_next  [ND];
    logic [CW-1:0]          mag_reg   [ND];
    logic [CW-1:0]          mag_next  [ND];
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic                   s1_cmd_reg;
    logic [wfpr_pkg::DIMS_W-1:0] dims_eff;
    logic                   accept;

    // Stage 2: walk state.
    logic [wfpr_pkg::COUNT_W-1:0] count_reg;
    logic [wfpr_pkg::COUNT_W-1:0] count_next;
    logic [wfpr_pkg::COUNT_W-1:0] count_inc;
    logic [NUM_LEVELS-1:0]        seen_reg;
    logic [NUM_LEVELS-1:0]        seen_next;
    logic                         ended_reg;
    logic                         ended_next;

    logic                   fire;
    logic [CW-1:0]          max01;
    logic [CW-1:0]          max23;
    logic [CW-1:0]          peak_mag;
    logic                   leaving;
    logic [NUM_LEVELS-1:0]  lim_hit;
    logic [NUM_LEVELS-1:0]  passed;
    logic [NUM_LEVELS-1:0]  upto_lim;
    logic [NUM_LEVELS-1:0]  unflagged;
    logic [NUM_LEVELS-1:0]  rec_mask;
    logic [wfpr_pkg::COUNT_W-1:0] rec_count;
    logic                   rec_end;

    assign in_ready = !s1_valid_reg || !q_status.full;
    assign accept   = in_valid && in_ready;
    assign fire     = s1_valid_reg && !q_status.full;

    always_comb
    begin
        if (dims_used == '0)
            dims_eff = wfpr_pkg::DIMS_W'(1);
        else if (dims_used > wfpr_pkg::DIMS_W'(DimLimit))
            dims_eff = wfpr_pkg::DIMS_W'(DimLimit);
        else
            dims_eff = dims_used;
    end

    always_comb
    begin
        logic [CW:0]   sum;
        logic [CW-1:0] p;
        for (int d = 0; d < ND; d++)
        begin
            sum = {pos_reg[d][CW-1], pos_reg[d]} + {in_step[d][CW-1], in_step[d]};
            if (sum[CW] != sum[CW-1])
                p = sum[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            else
                p = sum[CW-1:0];
            pos_next[d] = pos_reg[d];
            mag_next[d] = '0;
            if (in_cmd == wfpr_pkg::CMD_RESTART)
            begin
                pos_next[d] = '0;
            end
            else if (wfpr_pkg::DIMS_W'(d) < dims_eff)
            begin
                pos_next[d] = p;
                mag_next[d] = p[CW-1] ? (~p + CW'(1)) : p;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            for (int d = 0; d < ND; d++)
                pos_reg[d] <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
                pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= in_cmd;
            mag_reg    <= mag_next;
        end
    end

    // Stage 2: classify the step against the levels.
    always_comb
    begin
        max01    = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
        max23    = (mag_reg[2] > mag_reg[3]) ? mag_reg[2] : mag_reg[3];
        peak_mag = (max01 > max23) ? max01 : max23;
        leaving  = peak_mag >= {1'b0, region_limit};
        for (int k = 0; k < NUM_LEVELS; k++)
        begin
            lim_hit[k] = {1'b0, region_limit} == wfpr_pkg::level_threshold(k);
            passed[k]  = peak_mag >= wfpr_pkg::level_threshold(k);
        end
        // Levels at or below the one that equals the limit.
        for (int k = 0; k < NUM_LEVELS; k++)
            upto_lim[k] = |(lim_hit >> k);
        unflagged = ~seen_reg;
        count_inc = (count_reg == '1) ? count_reg : count_reg + wfpr_pkg::COUNT_W'(1);
    end

    // On leaving the region the pending levels are recorded at the old count,
    // and only then can the walk end; otherwise newly passed levels take the
    // incremented count.
    always_comb
    begin
        rec_end   = 1'b0;
        rec_mask  = '0;
        rec_count = count_inc;
        if (leaving)
        begin
            rec_count = count_reg;
            if (|(lim_hit & unflagged))
            begin
                rec_mask = unflagged & upto_lim;
                rec_end  = 1'b1;
            end
            else
            begin
                rec_mask = unflagged;
            end
        end
        else
        begin
            rec_mask = unflagged & passed;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        seen_next  = seen_reg;
        ended_next = ended_reg;
        if (fire)
        begin
            if (s1_cmd_reg == wfpr_pkg::CMD_RESTART)
            begin
                count_next = '0;
                seen_next  = '0;
                ended_next = 1'b0;
            end
            else if (!ended_reg)
            begin
                seen_next  = seen_reg | rec_mask;
                ended_next = rec_end;
                count_next = rec_end ? count_reg : count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            seen_reg  <= '0;
            ended_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            seen_reg  <= seen_next;
            ended_reg <= ended_next;
        end
    end

    assign push = fire && (s1_cmd_reg == wfpr_pkg::CMD_STEP) && !ended_reg && (|rec_mask);
    assign push_mask  = rec_mask;
    assign push_count = rec_count;
    assign push_end   = rec_end;

endmodule

// File: rtl/wfpr_queue.sv
// Small first-in first-out queue of record bursts between front and back.
// Depends on wfpr_pkg for the status type.
module wfpr_queue #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = wfpr_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    wdata,
    input  logic                pop,
    output logic [WIDTH-1:0]    rdata,
    output wfpr_pkg::q_status_t status
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg;
    logic [PtrW-1:0]  wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg;
    logic [PtrW-1:0]  rd_ptr_next;
    logic [CntW-1:0]  fill_reg;
    logic [CntW-1:0]  fill_next;

    assign status.full  = fill_reg == CntW'(DEPTH);
    assign status.empty = fill_reg == '0;
    assign rdata        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        if (push && !pop)
            fill_next = fill_reg + CntW'(1);
        else if (pop && !push)
            fill_next = fill_reg - CntW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// File: rtl/wfpr_back.sv
// Back part: expands each queued burst into level records, lowest level
// first, one per cycle while out_ready is high, through an output register. Depends on wfpr_pkg.
module wfpr_back #(
    parameter int unsigned NUM_LEVELS = wfpr_pkg::NUM_LEVELS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wfpr_pkg::q_status_t                  q_status,
    input  logic [NUM_LEVELS-1:0]                head_mask,
    input  logic [wfpr_pkg::COUNT_W-1:0]         head_count,
    input  logic                                 head_end,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [wfpr_pkg::LEVEL_IDX_W-1:0]     out_level,
    output logic [wfpr_pkg::COUNT_W-1:0]         out_count,
    output logic                                 out_ended,
    output logic                                 out_last
);

    logic                              work_valid_reg;
    logic                              work_valid_next;
    logic [NUM_LEVELS-1:0]             work_mask_reg;
    logic [NUM_LEVELS-1:0]             work_mask_next;
    logic [wfpr_pkg::COUNT_W-1:0]      work_count_reg;
    logic                              work_end_reg;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [wfpr_pkg::LEVEL_IDX_W-1:0]  out_level_reg;
    logic [wfpr_pkg::COUNT_W-1:0]      out_count_reg;
    logic                              out_ended_reg;
    logic                              out_last_reg;

    logic [wfpr_pkg::LEVEL_IDX_W-1:0]  low_level;
    logic [NUM_LEVELS-1:0]             rest_mask;
    logic                              is_last;
    logic                              emit;
    logic                              load;

    // Lowest pending level; the index is kept to the field width.
    always_comb
    begin
        low_level = '0;
        for (int k = NUM_LEVELS - 1; k >= 0; k--)
        begin
            if (work_mask_reg[k])
                low_level = wfpr_pkg::LEVEL_IDX_W'(k);
        end
        rest_mask = work_mask_reg & (work_mask_reg - NUM_LEVELS'(1));
        is_last   = rest_mask == '0;
    end

    assign emit = work_valid_reg && (!out_valid_reg || out_ready);
    assign load = !q_status.empty && (!work_valid_reg || (emit && is_last));
    assign pop  = load;

    always_comb
    begin
        work_valid_next = work_valid_reg;
        work_mask_next  = work_mask_reg;
        if (load)
        begin
            work_valid_next = 1'b1;
            work_mask_next  = head_mask;
        end
        else if (emit)
        begin
            work_valid_next = !is_last;
            work_mask_next  = rest_mask;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_mask_reg <= work_mask_next;
        if (load)
        begin
            work_count_reg <= head_count;
            work_end_reg   <= head_end;
        end
        if (emit)
        begin
            out_level_reg <= low_level;
            out_count_reg <= work_count_reg;
            out_last_reg  <= is_last;
            out_ended_reg <= work_end_reg && is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_level = out_level_reg;
    assign out_count = out_count_reg;
    assign out_ended = out_ended_reg;
    assign out_last  = out_last_reg;

endmodule

// File: rtl/walk_first_passage_recorder.sv
// Top level of the walk first-passage recorder: configuration registers,
// front classifier, burst queue and record emitter. Depends on wfpr_pkg.
//
// The block takes one restart or step transfer per clock cycle. A step passes
// a two-stage front (saturating position update, then level classification)
// and, when it passes new levels, leaves one burst entry in a queue of
// QUEUE_DEPTH entries; the back part sends one record per cycle from it while
// m_axis_tready is high, lowest level first, with tlast on the final record of
// the step. Input stalls only when that queue is full, so the sustained rate is
// one step per cycle as long as the record bursts average at most one record
// per step and the output is not stalled; the first record of a step passes the
// stage-one, queue, work and output registers before it is offered.
`include "walk_first_passage_recorder_defines.svh"

module walk_first_passage_recorder #(
    parameter int unsigned NUM_LEVELS  = wfpr_pkg::NUM_LEVELS,
    parameter int unsigned QUEUE_DEPTH = wfpr_pkg::QUEUE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // tdata: step_x0[31:0], step_x1[63:32], step_x2[95:64], step_x3[127:96]
    input  logic [127:0]                      s_axis_tdata,
    // tuser: cmd[0]
    input  logic [0:0]                        s_axis_tuser,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: level_index[3:0], steps_taken[35:4], zero fill[39:36]
    output logic [39:0]                       m_axis_tdata,
    // tuser: walk_ended[0]
    output logic [0:0]                        m_axis_tuser,
    output logic                              m_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              cfg_we,
    input  logic [wfpr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [wfpr_pkg::LIMIT_W-1:0]      cfg_wdata
);

    localparam int unsigned DescW = NUM_LEVELS + wfpr_pkg::COUNT_W + 1;

    logic [wfpr_pkg::LIMIT_W-1:0]     region_limit_reg;
    logic [wfpr_pkg::DIMS_W-1:0]      dims_used_reg;

    logic [wfpr_pkg::COORD_W-1:0]     step [wfpr_pkg::STEP_DIMS];
    wfpr_pkg::q_status_t              q_status;
    logic                             push;
    logic [NUM_LEVELS-1:0]            push_mask;
    logic [wfpr_pkg::COUNT_W-1:0]     push_count;
    logic                             push_end;
    logic                             pop;
    logic [DescW-1:0]                 head;
    logic [wfpr_pkg::LEVEL_IDX_W-1:0] out_level;
    logic [wfpr_pkg::COUNT_W-1:0]     out_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_limit_reg <= wfpr_pkg::REGION_LIMIT_RESET;
            dims_used_reg    <= wfpr_pkg::DIMS_USED_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                wfpr_pkg::REG_REGION_LIMIT: region_limit_reg <= cfg_wdata;
                wfpr_pkg::REG_DIMS_USED:    dims_used_reg    <= cfg_wdata[wfpr_pkg::DIMS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int d = 0; d < wfpr_pkg::STEP_DIMS; d++)
            step[d] = s_axis_tdata[d*wfpr_pkg::COORD_W +: wfpr_pkg::COORD_W];
    end

    wfpr_front #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_cmd       (s_axis_tuser[0]),
        .in_step      (step),
        .region_limit (region_limit_reg),
        .dims_used    (dims_used_reg),
        .q_status     (q_status),
        .push         (push),
        .push_mask    (push_mask),
        .push_count   (push_count),
        .push_end     (push_end)
    );

    wfpr_queue #(
        .WIDTH (DescW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  ({push_end, push_count, push_mask}),
        .pop    (pop),
        .rdata  (head),
        .status (q_status)
    );

    wfpr_back #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head_mask  (head[NUM_LEVELS-1:0]),
        .head_count (head[NUM_LEVELS +: wfpr_pkg::COUNT_W]),
        .head_end   (head[DescW-1]),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_level  (out_level),
        .out_count  (out_count),
        .out_ended  (m_axis_tuser[0]),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, out_count, out_level};

    // The front must never write into a full queue or queue an empty burst.
    `WFPR_NEVER(a_no_push_full, push && q_status.full)
    `WFPR_ASSERT(a_push_nonempty, push |-> (push_mask != '0))
    `WFPR_NEVER(a_queue_flags, q_status.full && q_status.empty)
    // The ending record is always the final record of its step.
    `WFPR_ASSERT(a_end_is_last, (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)

endmodule
